/* hw/rtl/crr_pkg.sv */
// Shared constants and types for the credit round-robin host picker.
`default_nettype none
package crr_pkg;

   localparam int Peers     = 16;
   localparam int IdxBits   = $clog2(Peers);
   localparam int LoadBits  = 8;
   localparam int IdBits    = 4;
   localparam int OpBits    = 3;
   localparam int CntBits   = IdxBits + 1;
   localparam int WordBits  = 2 * LoadBits;

   localparam logic [LoadBits-1:0] LoadMax        = {LoadBits{1'b1}};
   localparam logic [LoadBits-1:0] LocalLimitInit = LoadBits'(16);

   typedef enum logic [OpBits-1:0] {
      OP_JOIN   = 3'd0,
      OP_LEAVE  = 3'd1,
      OP_ADD    = 3'd2,
      OP_REMOVE = 3'd3,
      OP_STATUS = 3'd4,
      OP_PICK   = 3'd5
   } op_type;

   // csr word select, taken from paddr[2]
   localparam logic CSR_MY_ID       = 1'b0;
   localparam logic CSR_LOCAL_LIMIT = 1'b1;

endpackage
`default_nettype wire

/* hw/rtl/credit_round_robin_host_picker.sv */
// Top level: peer table in a synchronous memory, op sequencer and round-robin pick scan.
//
// Usage: drive req_* and raise start while busy is low; the command word is taken
// at that edge and busy stays high until its result is shown. Each command
// yields exactly one result word, shown on the rsp_* ports for one cycle with
// rsp_valid high; the receiver must take it then, it cannot stall the block.
// Join, leave, load add, load remove, status set and unused codes read the table
// entry in the fetch state, modify and write it back in the exec state, and then
// register the result. A pick scans the table one entry per cycle from the
// round-robin pointer through the single read port of the table memory, whose
// read data is registered; the first valid entry with room wins, and when no
// entry has room the pick ends once every entry has been checked.
// busy drops with the result strobe, so the next command can be taken at the edge
// that ends the strobe cycle.
// Reset (synchronous, active high) clears all valid marks, the pointer, the
// local load, my_id (0) and local_limit (16); the table memory itself is not
// cleared, entries are written by join before they count as valid.
// The APB-style csr port holds my_id at address 0 and local_limit at address 4;
// write it only while busy is low.
`default_nettype none
module credit_round_robin_host_picker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // command channel
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [crr_pkg::OpBits-1:0]     req_op,
   input  wire logic [crr_pkg::IdBits-1:0]     req_peer_id,
   input  wire logic [crr_pkg::LoadBits-1:0]   req_load_count,
   input  wire logic [crr_pkg::LoadBits-1:0]   req_load_limit,
   // result channel
   output logic                                rsp_valid,
   output logic [crr_pkg::IdBits-1:0]          rsp_host_id,
   output logic                                rsp_host_found,
   output logic                                rsp_msg_valid,
   output logic                                rsp_msg_broadcast,
   output logic [crr_pkg::IdBits-1:0]          rsp_msg_dest,
   output logic [crr_pkg::LoadBits-1:0]        rsp_msg_load,
   output logic [crr_pkg::LoadBits-1:0]        rsp_msg_limit,
   output logic                                rsp_peer_missing,
   output logic                                rsp_may_process,
   // csr port
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [2:0]                     paddr,
   input  wire logic [31:0]                    pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_SCAN
   } state_type;

   localparam int LB = crr_pkg::LoadBits;

   // ---------------------------------------------------------------- csr
   logic [crr_pkg::IdBits-1:0] my_id_ff;
   logic [LB-1:0]              local_limit_ff;
   logic                       csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         my_id_ff       <= '0;
         local_limit_ff <= crr_pkg::LocalLimitInit;
      end else if (csr_wr) begin
         if (paddr[2] == crr_pkg::CSR_MY_ID) begin
            my_id_ff <= pwdata[crr_pkg::IdBits-1:0];
         end else begin
            local_limit_ff <= pwdata[LB-1:0];
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == crr_pkg::CSR_LOCAL_LIMIT) begin
         prdata[LB-1:0] = local_limit_ff;
      end else begin
         prdata[crr_pkg::IdBits-1:0] = my_id_ff;
      end
   end

   // ---------------------------------------------------------------- table memory
   // word layout: {limit, load}
   logic [crr_pkg::WordBits-1:0] table_mem [crr_pkg::Peers];
   logic [crr_pkg::IdxBits-1:0]  rd_addr;
   logic [crr_pkg::WordBits-1:0] rd_data_ff;
   logic                         wr_en;
   logic [crr_pkg::IdxBits-1:0]  wr_addr;
   logic [crr_pkg::WordBits-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   // ---------------------------------------------------------------- sequencer
   state_type                    state_ff, state_in;
   logic [crr_pkg::OpBits-1:0]   op_ff, op_in;
   logic [crr_pkg::IdBits-1:0]   id_ff, id_in;
   logic [LB-1:0]                lc_ff, lc_in;
   logic [LB-1:0]                ll_ff, ll_in;
   logic [crr_pkg::Peers-1:0]    valid_ff, valid_in;
   logic [crr_pkg::IdxBits-1:0]  ptr_ff, ptr_in;
   logic [LB-1:0]                local_load_ff, local_load_in;
   logic [crr_pkg::CntBits-1:0]  issue_cnt_ff, issue_cnt_in;
   logic                         chk_pend_ff, chk_pend_in;
   logic [crr_pkg::IdxBits-1:0]  chk_idx_ff, chk_idx_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [crr_pkg::IdBits-1:0]   host_id_ff, host_id_in;
   logic                         host_found_ff, host_found_in;
   logic                         msg_valid_ff, msg_valid_in;
   logic                         msg_bcast_ff, msg_bcast_in;
   logic [crr_pkg::IdBits-1:0]   msg_dest_ff, msg_dest_in;
   logic [LB-1:0]                msg_load_ff, msg_load_in;
   logic [LB-1:0]                msg_limit_ff, msg_limit_in;
   logic                         missing_ff, missing_in;
   logic                         may_ff, may_in;

   logic [LB-1:0]                rd_load;
   logic [LB-1:0]                rd_limit;
   logic [crr_pkg::IdxBits-1:0]  id_idx;
   logic                         in_range;
   logic                         present;
   logic                         is_self;
   logic [LB-1:0]                new_load;
   logic                         hit;
   logic                         result_now;

   assign rd_load  = rd_data_ff[LB-1:0];
   assign rd_limit = rd_data_ff[2*LB-1:LB];
   assign id_idx   = id_ff[crr_pkg::IdxBits-1:0];
   assign in_range = 32'(id_ff) < crr_pkg::Peers;
   assign present  = in_range && valid_ff[id_idx];
   assign is_self  = (id_ff == my_id_ff);
   assign hit      = chk_pend_ff && valid_ff[chk_idx_ff] && (rd_limit > rd_load);

   always_comb begin
      if (op_ff == crr_pkg::OP_ADD) begin
         new_load = (rd_load == crr_pkg::LoadMax) ? rd_load : rd_load + LB'(1);
      end else begin
         new_load = (rd_load == '0) ? rd_load : rd_load - LB'(1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      lc_in         = lc_ff;
      ll_in         = ll_ff;
      valid_in      = valid_ff;
      ptr_in        = ptr_ff;
      local_load_in = local_load_ff;
      issue_cnt_in  = issue_cnt_ff;
      chk_pend_in   = 1'b0;
      chk_idx_in    = chk_idx_ff;

      rsp_valid_in  = 1'b0;
      host_id_in    = '0;
      host_found_in = 1'b0;
      msg_valid_in  = 1'b0;
      msg_bcast_in  = 1'b0;
      msg_dest_in   = '0;
      msg_load_in   = '0;
      msg_limit_in  = '0;
      missing_in    = 1'b0;
      result_now    = 1'b0;

      rd_addr = id_idx;
      wr_en   = 1'b0;
      wr_addr = id_idx;
      wr_data = rd_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in        = req_op;
               id_in        = req_peer_id;
               lc_in        = req_load_count;
               ll_in        = req_load_limit;
               issue_cnt_in = '0;
               state_in     = (req_op == crr_pkg::OP_PICK) ? ST_SCAN : ST_FETCH;
            end
         end

         ST_FETCH: begin
            state_in = ST_EXEC;
         end

         ST_EXEC: begin
            result_now = 1'b1;
            state_in   = ST_IDLE;
            case (op_ff) inside
               crr_pkg::OP_JOIN: begin
                  if (!in_range) begin
                     missing_in = 1'b1;
                  end else begin
                     valid_in[id_idx] = 1'b1;
                     wr_en = 1'b1;
                     if (is_self) begin
                        wr_data = {local_limit_ff, local_load_ff};
                     end else begin
                        wr_data      = '0;
                        msg_valid_in = 1'b1;
                        msg_dest_in  = id_ff;
                        msg_load_in  = local_load_ff;
                        msg_limit_in = local_limit_ff;
                     end
                  end
               end
               crr_pkg::OP_LEAVE: begin
                  if (!present) begin
                     missing_in = 1'b1;
                  end else begin
                     valid_in[id_idx] = 1'b0;
                  end
               end
               crr_pkg::OP_ADD, crr_pkg::OP_REMOVE: begin
                  if (!present) begin
                     missing_in = 1'b1;
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = {rd_limit, new_load};
                     if (is_self) begin
                        local_load_in = new_load;
                        msg_valid_in  = 1'b1;
                        msg_bcast_in  = 1'b1;
                        msg_load_in   = new_load;
                        msg_limit_in  = local_limit_ff;
                     end
                  end
               end
               crr_pkg::OP_STATUS: begin
                  if (!present) begin
                     missing_in = 1'b1;
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = {ll_ff, lc_ff};
                     if (is_self) begin
                        msg_valid_in = 1'b1;
                        msg_bcast_in = 1'b1;
                        msg_load_in  = lc_ff;
                        msg_limit_in = ll_ff;
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         ST_SCAN: begin
            // issue one read per cycle, check the word read in the cycle before
            rd_addr = ptr_ff + issue_cnt_ff[crr_pkg::IdxBits-1:0];
            if (32'(issue_cnt_ff) < crr_pkg::Peers) begin
               chk_pend_in  = 1'b1;
               chk_idx_in   = rd_addr;
               issue_cnt_in = issue_cnt_ff + crr_pkg::CntBits'(1);
            end
            host_id_in = my_id_ff;
            if (hit) begin
               result_now    = 1'b1;
               host_id_in    = crr_pkg::IdBits'(chk_idx_ff);
               host_found_in = 1'b1;
               ptr_in        = chk_idx_ff + crr_pkg::IdxBits'(1);
               chk_pend_in   = 1'b0;
               state_in      = ST_IDLE;
            end else if (chk_pend_ff && 32'(issue_cnt_ff) == crr_pkg::Peers) begin
               // last entry checked without room: fall back to local id
               result_now  = 1'b1;
               chk_pend_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (!result_now) begin
         host_id_in = '0;
      end
      rsp_valid_in = result_now;
      may_in       = local_load_in < local_limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= '0;
         id_ff         <= '0;
         lc_ff         <= '0;
         ll_ff         <= '0;
         valid_ff      <= '0;
         ptr_ff        <= '0;
         local_load_ff <= '0;
         issue_cnt_ff  <= '0;
         chk_pend_ff   <= 1'b0;
         chk_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         host_id_ff    <= '0;
         host_found_ff <= 1'b0;
         msg_valid_ff  <= 1'b0;
         msg_bcast_ff  <= 1'b0;
         msg_dest_ff   <= '0;
         msg_load_ff   <= '0;
         msg_limit_ff  <= '0;
         missing_ff    <= 1'b0;
         may_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         id_ff         <= id_in;
         lc_ff         <= lc_in;
         ll_ff         <= ll_in;
         valid_ff      <= valid_in;
         ptr_ff        <= ptr_in;
         local_load_ff <= local_load_in;
         issue_cnt_ff  <= issue_cnt_in;
         chk_pend_ff   <= chk_pend_in;
         chk_idx_ff    <= chk_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         host_id_ff    <= host_id_in;
         host_found_ff <= host_found_in;
         msg_valid_ff  <= msg_valid_in;
         msg_bcast_ff  <= msg_bcast_in;
         msg_dest_ff   <= msg_dest_in;
         msg_load_ff   <= msg_load_in;
         msg_limit_ff  <= msg_limit_in;
         missing_ff    <= missing_in;
         may_ff        <= may_in;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_host_id       = host_id_ff;
   assign rsp_host_found    = host_found_ff;
   assign rsp_msg_valid     = msg_valid_ff;
   assign rsp_msg_broadcast = msg_bcast_ff;
   assign rsp_msg_dest      = msg_dest_ff;
   assign rsp_msg_load      = msg_load_ff;
   assign rsp_msg_limit     = msg_limit_ff;
   assign rsp_peer_missing  = missing_ff;
   assign rsp_may_process   = may_ff;

endmodule
`default_nettype wire
